// File: src/drivetrain_wheel_mixer_top_macros.svh
// Assertion macros for the wheel mixer top level.
// Depends on nothing; included by drivetrain_wheel_mixer_top.sv.
`ifndef DRIVETRAIN_WHEEL_MIXER_TOP_MACROS_SVH
`define DRIVETRAIN_WHEEL_MIXER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset
`define DWM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define DWM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/dwm_pkg.sv
// Shared types, constants and helper functions of the wheel mixer.
// No dependencies; used by every module of the block.
package dwm_pkg;

    localparam int LANES     = 4;
    localparam int MIX_LIMIT = 127;
    localparam int DIV2_MIN  = 2 * MIX_LIMIT;
    localparam int DIV3_MIN  = 3 * MIX_LIMIT;

    // Lane order: left front, left rear, right front, right rear
    localparam int LANE_LF = 0;
    localparam int LANE_LR = 1;
    localparam int LANE_RF = 2;
    localparam int LANE_RR = 3;

    typedef enum logic [1:0] {
        MODE_ARCADE = 2'd0,
        MODE_TANK   = 2'd1,
        MODE_HOLO   = 2'd2,
        MODE_STOP   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        DIV_ONE   = 2'd1,
        DIV_TWO   = 2'd2,
        DIV_THREE = 2'd3
    } t_div;

    // Stage 1: direct lane values for non-mecanum modes, raw mecanum sums
    typedef struct packed {
        logic                  holo;
        logic [LANES-1:0][7:0] dir;
        logic [LANES-1:0][9:0] sum;
    } t_s1;

    // Stage 2: sign and clamped magnitude per lane, common divisor
    typedef struct packed {
        logic                  holo;
        logic [LANES-1:0][7:0] dir;
        logic [LANES-1:0]      neg;
        logic [LANES-1:0][6:0] mag;
        t_div                  div;
    } t_s2;

    // Stage 3: sign and scaled magnitude per lane
    typedef struct packed {
        logic                  holo;
        logic [LANES-1:0][7:0] dir;
        logic [LANES-1:0]      neg;
        logic [LANES-1:0][6:0] mag;
    } t_s3;

    // Clamp a 9-bit signed sum to +/-127
    function automatic logic [7:0] clamp9(input logic signed [8:0] v);
        logic [7:0] res;
        if (v > 9'sd127) begin
            res = 8'sd127;
        end else if (v < -9'sd127) begin
            res = -8'sd127;
        end else begin
            res = v[7:0];
        end
        return res;
    endfunction

endpackage

// File: src/dwm_mix.sv
// First pipeline stage: arcade, tank and stop values plus the four mecanum sums.
// Depends on dwm_pkg.
module dwm_mix (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dwm_pkg::t_mode     i_mode,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [7:0]  i_fwd,
    input  logic signed [7:0]  i_side,
    input  logic signed [7:0]  i_rot,
    output logic               o_valid,
    input  logic               i_ready,
    output dwm_pkg::t_s1       o_data
);

    logic         r_valid;
    dwm_pkg::t_s1 r_data;
    dwm_pkg::t_s1 n_data;
    logic [7:0]   arc_l;
    logic [7:0]   arc_r;
    logic signed [9:0] f10;
    logic signed [9:0] s10;
    logic signed [9:0] r10;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // Form arcade sums, mecanum sums and the direct lane values
    always_comb begin
        f10   = 10'(i_fwd);
        s10   = 10'(i_side);
        r10   = 10'(i_rot);
        arc_l = dwm_pkg::clamp9(9'(i_fwd) + 9'(i_side));
        arc_r = dwm_pkg::clamp9(9'(i_fwd) - 9'(i_side));

        n_data      = '0;
        n_data.holo = (i_mode == dwm_pkg::MODE_HOLO);
        n_data.sum[dwm_pkg::LANE_LF] = f10 + s10 + r10;
        n_data.sum[dwm_pkg::LANE_LR] = f10 - s10 + r10;
        n_data.sum[dwm_pkg::LANE_RF] = f10 - s10 - r10;
        n_data.sum[dwm_pkg::LANE_RR] = f10 + s10 - r10;

        unique case (i_mode)
            dwm_pkg::MODE_ARCADE: begin
                n_data.dir[dwm_pkg::LANE_LF] = arc_l;
                n_data.dir[dwm_pkg::LANE_LR] = arc_l;
                n_data.dir[dwm_pkg::LANE_RF] = arc_r;
                n_data.dir[dwm_pkg::LANE_RR] = arc_r;
            end
            dwm_pkg::MODE_TANK: begin
                n_data.dir[dwm_pkg::LANE_LF] = i_fwd;
                n_data.dir[dwm_pkg::LANE_LR] = i_fwd;
                n_data.dir[dwm_pkg::LANE_RF] = i_side;
                n_data.dir[dwm_pkg::LANE_RR] = i_side;
            end
            default: begin
                n_data.dir = '0;
            end
        endcase
    end

    // Advance valid; load payload on accept
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (i_valid && o_ready) begin
            r_data <= n_data;
        end
    end

endmodule

// File: src/dwm_norm.sv
// Second and third pipeline stages: sign/magnitude, largest magnitude and
// divisor, then the divide by 1, 2 or 3. Depends on dwm_pkg.
module dwm_norm (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  dwm_pkg::t_s1  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output dwm_pkg::t_s3  o_data
);

    logic                                r_v2;
    logic                                r_v3;
    dwm_pkg::t_s2                        r_s2;
    dwm_pkg::t_s3                        r_s3;
    dwm_pkg::t_s2                        n_s2;
    dwm_pkg::t_s3                        n_s3;
    logic                                s3_ready;
    logic [dwm_pkg::LANES-1:0][9:0]      abs_v;
    logic [9:0]                          max_a;
    logic [9:0]                          max_b;
    logic [9:0]                          max_v;
    logic [dwm_pkg::LANES-1:0][14:0]     prod3;

    assign s3_ready = !r_v3 || i_ready;
    assign o_ready  = !r_v2 || s3_ready;
    assign o_valid  = r_v3;
    assign o_data   = r_s3;

    // Split sums into sign and magnitude, clamp, pick the divisor
    always_comb begin
        n_s2      = '0;
        n_s2.holo = i_data.holo;
        n_s2.dir  = i_data.dir;
        for (int i = 0; i < dwm_pkg::LANES; i++) begin
            n_s2.neg[i] = i_data.sum[i][9];
            abs_v[i]    = i_data.sum[i][9] ? 10'(-$signed(i_data.sum[i])) : i_data.sum[i];
            n_s2.mag[i] = (abs_v[i] > 10'(dwm_pkg::MIX_LIMIT)) ?
                          7'(dwm_pkg::MIX_LIMIT) : abs_v[i][6:0];
        end
        max_a = (abs_v[0] > abs_v[1]) ? abs_v[0] : abs_v[1];
        max_b = (abs_v[2] > abs_v[3]) ? abs_v[2] : abs_v[3];
        max_v = (max_a > max_b) ? max_a : max_b;
        if (max_v >= 10'(dwm_pkg::DIV3_MIN)) begin
            n_s2.div = dwm_pkg::DIV_THREE;
        end else if (max_v >= 10'(dwm_pkg::DIV2_MIN)) begin
            n_s2.div = dwm_pkg::DIV_TWO;
        end else begin
            n_s2.div = dwm_pkg::DIV_ONE;
        end
    end

    // Divide magnitudes; divide by three as multiply by 171 and shift by 9
    always_comb begin
        n_s3      = '0;
        n_s3.holo = r_s2.holo;
        n_s3.dir  = r_s2.dir;
        n_s3.neg  = r_s2.neg;
        for (int i = 0; i < dwm_pkg::LANES; i++) begin
            prod3[i] = 15'(r_s2.mag[i]) * 15'd171;
            unique case (r_s2.div)
                dwm_pkg::DIV_THREE: n_s3.mag[i] = 7'(prod3[i][14:9]);
                dwm_pkg::DIV_TWO:   n_s3.mag[i] = 7'(r_s2.mag[i][6:1]);
                default:            n_s3.mag[i] = r_s2.mag[i];
            endcase
        end
    end

    // Advance both stages, each holding while its successor stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (o_ready) begin
                r_v2 <= i_valid;
            end
            if (s3_ready) begin
                r_v3 <= r_v2;
            end
        end
        if (i_valid && o_ready) begin
            r_s2 <= n_s2;
        end
        if (r_v2 && s3_ready) begin
            r_s3 <= n_s3;
        end
    end

endmodule

// File: src/dwm_quant.sv
// Output stage: truncate mecanum values to multiples of ten, restore the sign,
// select per mode and hold the result item. Depends on dwm_pkg.
module dwm_quant (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  dwm_pkg::t_s3                       i_data,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [dwm_pkg::LANES-1:0][7:0]     o_drive
);

    logic                                 r_valid;
    logic [dwm_pkg::LANES-1:0][7:0]       r_drive;
    logic [dwm_pkg::LANES-1:0][7:0]       n_drive;
    logic [dwm_pkg::LANES-1:0][14:0]      prod10;
    logic [dwm_pkg::LANES-1:0][3:0]       tens;
    logic [dwm_pkg::LANES-1:0][6:0]       rounded;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_drive = r_drive;

    // Divide by ten as multiply by 205 and shift by 11, then scale back by ten
    always_comb begin
        for (int i = 0; i < dwm_pkg::LANES; i++) begin
            prod10[i]  = 15'(i_data.mag[i]) * 15'd205;
            tens[i]    = prod10[i][14:11];
            rounded[i] = 7'({tens[i], 3'b000}) + 7'({tens[i], 1'b0});
            if (i_data.holo) begin
                n_drive[i] = i_data.neg[i] ? 8'(-$signed({1'b0, rounded[i]}))
                                           : {1'b0, rounded[i]};
            end else begin
                n_drive[i] = i_data.dir[i];
            end
        end
    end

    // Hold the result item until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (i_valid && o_ready) begin
            r_drive <= n_drive;
        end
    end

endmodule

// File: src/drivetrain_wheel_mixer_top.sv
// Four register stages: mix, sign/magnitude, divide and output; the first loads on
// accept. Throughput: one item per cycle; each stage holds only while its successor
// stalls, so the input stays ready until every stage is full. Reset (i_rst_n,
// synchronous, active low) empties the pipeline and sets the drive mode to arcade.
// Depends on dwm_pkg, dwm_mix, dwm_norm, dwm_quant and the macros header.
`include "drivetrain_wheel_mixer_top_macros.svh"

module drivetrain_wheel_mixer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_wdata,     // drive_mode
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,    // forward_axis, side_axis, rotate_axis
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata     // left_front, left_rear, right_front, right_rear
);

    dwm_pkg::t_mode                       r_mode;
    logic                                 s1_valid;
    logic                                 s1_ready;
    dwm_pkg::t_s1                         s1_data;
    logic                                 s3_valid;
    logic                                 s3_ready;
    dwm_pkg::t_s3                         s3_data;
    logic [dwm_pkg::LANES-1:0][7:0]       drive;

    // Hold the drive mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= dwm_pkg::MODE_ARCADE;
        end else if (i_cfg_we) begin
            r_mode <= dwm_pkg::t_mode'(i_cfg_wdata);
        end
    end

    dwm_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mode  (r_mode),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_fwd   (s_axis_tdata[7:0]),
        .i_side  (s_axis_tdata[15:8]),
        .i_rot   (s_axis_tdata[23:16]),
        .o_valid (s1_valid),
        .i_ready (s1_ready),
        .o_data  (s1_data)
    );

    dwm_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .o_ready (s1_ready),
        .i_data  (s1_data),
        .o_valid (s3_valid),
        .i_ready (s3_ready),
        .o_data  (s3_data)
    );

    dwm_quant u_quant (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s3_valid),
        .o_ready (s3_ready),
        .i_data  (s3_data),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_drive (drive)
    );

    assign m_axis_tdata = drive;

    // Input backpressure only when every stage holds an item
    `DWM_ASSERT_NOW(a_stall_only_full, i_clk, i_rst_n, !s_axis_tready, s1_valid && s3_valid && m_axis_tvalid && !m_axis_tready, "input stalled with room in pipeline")

    // Non-mecanum items drive both wheels of a side alike
    `DWM_ASSERT_NOW(a_side_pairs, i_clk, i_rst_n, s1_valid && !s1_data.holo, (s1_data.dir[dwm_pkg::LANE_LF] == s1_data.dir[dwm_pkg::LANE_LR]) && (s1_data.dir[dwm_pkg::LANE_RF] == s1_data.dir[dwm_pkg::LANE_RR]), "side lanes differ outside mecanum mode")

    // A stalled result item stays valid and unchanged until taken
    `DWM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

endmodule

// File: bench/tb_drivetrain_wheel_mixer_top.sv
// Self-checking bench for the wheel mixer top level: drives stick items,
// predicts the four wheel drives per item and compares every result.
// Depends on dwm_pkg and drivetrain_wheel_mixer_top.
module tb_drivetrain_wheel_mixer_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES   = 120;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS   = 100;

    // Packed like m_axis_tdata: left front in the lowest byte
    typedef struct packed {
        logic [7:0] rr;
        logic [7:0] rf;
        logic [7:0] lr;
        logic [7:0] lf;
    } t_wheels;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [1:0]  i_cfg_wdata   = 2'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = 24'd0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;

    t_wheels        wheel_expect_q[$];
    dwm_pkg::t_mode cur_mode    = dwm_pkg::MODE_ARCADE;
    bit      idle_on     = 1'b1;
    bit      hold_req    = 1'b0;
    int      hold_left   = 0;
    int      rx_gap      = 0;
    int      error_count = 0;
    int      items_sent  = 0;
    int      results_seen = 0;
    string   lane_names[4] = '{"left_front", "left_rear", "right_front", "right_rear"};

    drivetrain_wheel_mixer_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #2 i_clk = ~i_clk;

    // Clamp a lane value to the motor range
    function automatic int limit_drive(input int v);
        if (v > 127) begin
            return 127;
        end
        if (v < -127) begin
            return -127;
        end
        return v;
    endfunction

    // Work out the four wheel drives for one stick item
    function automatic t_wheels mix_wheels(input dwm_pkg::t_mode mode,
                                           input logic signed [7:0] fwd,
                                           input logic signed [7:0] side,
                                           input logic signed [7:0] rot);
        int      f;
        int      s;
        int      r;
        int      lane[4];
        int      peak;
        int      divisor;
        t_wheels res;
        f = fwd;
        s = side;
        r = rot;
        lane = '{0, 0, 0, 0};
        case (mode)
            dwm_pkg::MODE_ARCADE: begin
                lane[0] = limit_drive(f + s);
                lane[1] = lane[0];
                lane[2] = limit_drive(f - s);
                lane[3] = lane[2];
            end
            dwm_pkg::MODE_TANK: begin
                lane = '{f, f, s, s};
            end
            dwm_pkg::MODE_HOLO: begin
                lane = '{f + s + r, f - s + r, f - s - r, f + s - r};
                peak = 0;
                for (int k = 0; k < 4; k++) begin
                    if ((lane[k] < 0 ? -lane[k] : lane[k]) > peak) begin
                        peak = lane[k] < 0 ? -lane[k] : lane[k];
                    end
                end
                if (peak > 127) begin
                    divisor = peak / 127;
                    for (int k = 0; k < 4; k++) begin
                        lane[k] = limit_drive(lane[k]) / divisor;
                    end
                end
                for (int k = 0; k < 4; k++) begin
                    lane[k] = (lane[k] / 10) * 10;
                end
            end
            default: begin
                lane = '{0, 0, 0, 0};
            end
        endcase
        res.lf = 8'(lane[0]);
        res.lr = 8'(lane[1]);
        res.rf = 8'(lane[2]);
        res.rr = 8'(lane[3]);
        return res;
    endfunction

    // Print one mismatch line and count it
    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Offer one stick item, optionally after an idle burst; leave tvalid high
    task automatic send_item(input logic [7:0] fwd, input logic [7:0] side,
                             input logic [7:0] rot);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 14);
        end
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {rot, side, fwd};
        do @(posedge i_clk); while (!s_axis_tready);
        wheel_expect_q.push_back(mix_wheels(cur_mode, fwd, side, rot));
        items_sent++;
    endtask

    // Wait for outstanding results, then let the pipeline settle
    task automatic drain_results();
        int waited;
        waited = 0;
        while (wheel_expect_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (wheel_expect_q.size() != 0) begin
            report_mismatch($sformatf("%0d expected results never arrived",
                                      wheel_expect_q.size()));
            wheel_expect_q.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write the drive mode with the block idle
    task automatic set_mode(input dwm_pkg::t_mode mode);
        s_axis_tvalid <= 1'b0;
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= mode;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur_mode = mode;
    endtask

    // Random stick value, biased toward the range ends and zero
    function automatic logic [7:0] pick_axis();
        logic [7:0] v;
        case ($urandom_range(0, 11))
            0:       v = 8'h80;
            1:       v = 8'h81;
            2:       v = 8'h7F;
            3:       v = 8'h00;
            default: v = 8'($urandom_range(0, 255));
        endcase
        return v;
    endfunction

    // Arcade mixing from the reset mode: clamping both ways, rotation ignored
    task automatic test_arcade_extremes();
        send_item(8'sd127, 8'sd127, 8'sd0);
        send_item(-8'sd128, -8'sd128, 8'sd0);
        send_item(-8'sd128, 8'sd127, 8'sd127);
        send_item(8'sd127, -8'sd128, -8'sd128);
        send_item(8'sd0, 8'sd0, 8'sd0);
        send_item(8'sd10, 8'sd20, -8'sd128);
    endtask

    // Tank pass-through, including the most negative stick value
    task automatic test_tank_passthrough();
        set_mode(dwm_pkg::MODE_TANK);
        send_item(-8'sd128, 8'sd127, 8'sd55);
        send_item(8'sd127, -8'sd128, -8'sd1);
        send_item(8'sd0, 8'sd0, 8'sd0);
    endtask

    // Mecanum sums: divisors of one, two and three, rounding toward zero
    task automatic test_holonomic_scaling();
        set_mode(dwm_pkg::MODE_HOLO);
        send_item(8'sd127, 8'sd127, 8'sd127);
        send_item(-8'sd128, -8'sd128, -8'sd128);
        send_item(8'sd127, 8'sd127, 8'sd0);
        send_item(8'sd100, 8'sd100, 8'sd30);
        send_item(8'sd0, 8'sd0, 8'sd0);
        send_item(8'sd15, -8'sd7, 8'sd3);
        send_item(-8'sd19, 8'sd0, 8'sd0);
        send_item(8'sd9, -8'sd9, 8'sd0);
        send_item(-8'sd128, 8'sd127, -8'sd128);
    endtask

    // Stop mode drives all motors to zero
    task automatic test_stop_mode();
        set_mode(dwm_pkg::MODE_STOP);
        send_item(8'sd127, -8'sd128, 8'sd5);
        send_item(-8'sd128, 8'sd127, -8'sd77);
    endtask

    // Hold the output off long enough for the input to stall
    task automatic test_input_backpressure();
        set_mode(dwm_pkg::MODE_HOLO);
        idle_on  = 1'b0;
        hold_req = 1'b1;
        repeat (40) send_item(pick_axis(), pick_axis(), pick_axis());
        idle_on = 1'b1;
    endtask

    // Random items in phases over every mode; last phase runs without idling
    task automatic test_random_mix();
        dwm_pkg::t_mode phase_modes[8];
        phase_modes = '{dwm_pkg::MODE_HOLO, dwm_pkg::MODE_ARCADE, dwm_pkg::MODE_TANK,
                        dwm_pkg::MODE_STOP, dwm_pkg::MODE_HOLO, dwm_pkg::MODE_ARCADE,
                        dwm_pkg::MODE_TANK, dwm_pkg::MODE_HOLO};
        for (int p = 0; p < 8; p++) begin
            set_mode(phase_modes[p]);
            if (p == 7) begin
                idle_on = 1'b0;
            end
            repeat (PHASE_ITEMS) send_item(pick_axis(), pick_axis(), pick_axis());
        end
        s_axis_tvalid <= 1'b0;
    endtask

    // Receiver: long hold-off on request, otherwise random stall bursts while idling is on
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            m_axis_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rx_gap = $urandom_range(0, 13);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_wheels want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (wheel_expect_q.size() == 0) begin
                report_mismatch($sformatf("result %08h with nothing expected", m_axis_tdata));
            end else begin
                want = wheel_expect_q.pop_front();
                for (int k = 0; k < 4; k++) begin
                    if (m_axis_tdata[8*k +: 8] !== want[8*k +: 8]) begin
                        report_mismatch($sformatf("%s got %0d want %0d", lane_names[k],
                                                  $signed(m_axis_tdata[8*k +: 8]),
                                                  $signed(want[8*k +: 8])));
                    end
                end
            end
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_arcade_extremes();
        test_tank_passthrough();
        test_holonomic_scaling();
        test_stop_mode();
        test_input_backpressure();
        test_random_mix();
        drain_results();
        $display("Checked %0d results from %0d items over arcade, tank, mecanum and stop modes",
                 results_seen, items_sent);
        $display("Run included a %0d-cycle output hold-off with the input stalled", HOLD_CYCLES);
        if (error_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
